FILE: sv/ldsw_pkg.sv
// Shared constants and types for the LED display serial writer.
`timescale 1ns / 1ps
`default_nettype none

package ldsw_pkg;

  localparam logic [1:0] ACT_DISPLAY_ON = 2'd0;
  localparam logic [1:0] ACT_DIGIT      = 2'd1;
  localparam logic [1:0] ACT_LED        = 2'd2;

  localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
  localparam logic [3:0] CMD_ADDR_HI    = 4'hC;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
  localparam logic [7:0] DOT_BIT        = 8'h80;
  localparam logic [2:0] DOT_POSITION   = 3'd6;

  typedef struct packed {
    logic load;
    logic step;
  } shift_ctl_t;

  typedef struct packed {
    logic bit_val;
    logic phase;
    logic done;
  } shift_stat_t;

  typedef struct packed {
    logic       long_frame;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } job_t;

endpackage

`default_nettype wire

FILE: sv/ldsw_shifter.sv
// Byte shift register that serializes one bit per low and high phase, LSB first.
`timescale 1ns / 1ps
`default_nettype none

module ldsw_shifter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ldsw_pkg::shift_ctl_t ctl,
  input  wire logic [7:0]          load_byte,
  output ldsw_pkg::shift_stat_t    stat
);
  import ldsw_pkg::*;

  logic [7:0] sr_r, sr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       phase_r, phase_nxt;

  always_comb begin
    sr_nxt    = sr_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    if (ctl.load) begin
      sr_nxt    = load_byte;
      cnt_nxt   = 3'd0;
      phase_nxt = 1'b0;
    end else if (ctl.step) begin
      phase_nxt = ~phase_r;
      if (phase_r) begin
        sr_nxt  = {1'b0, sr_r[7:1]};
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      phase_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign stat.bit_val = sr_r[0];
  assign stat.phase   = phase_r;
  assign stat.done    = (cnt_r == 3'd7) && phase_r;

endmodule

`default_nettype wire

FILE: sv/ldsw_seq.sv
// Frame sequencer: strobe framing, pin levels and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ldsw_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire ldsw_pkg::job_t job,
  output logic                idle,
  input  wire logic           out_tready,
  output logic                out_tvalid,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);
  import ldsw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STB0,
    ST_BYTE0,
    ST_STB1,
    ST_STB2,
    ST_BYTE1,
    ST_BYTE2,
    ST_STB3
  } state_t;

  state_t      state_r, state_nxt;
  logic        strobe_r, strobe_nxt;
  logic        clock_r, clock_nxt;
  logic        data_r, data_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [7:0]  out_tdata_r, out_tdata_nxt;
  logic        out_tlast_r, out_tlast_nxt;
  logic        fire;
  shift_ctl_t  sh_ctl;
  shift_stat_t sh_stat;
  logic [7:0]  sh_byte;

  ldsw_shifter u_shifter (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sh_ctl),
    .load_byte (sh_byte),
    .stat      (sh_stat)
  );

  assign fire = (state_r != ST_IDLE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    strobe_nxt     = strobe_r;
    clock_nxt      = clock_r;
    data_nxt       = data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    sh_ctl         = '0;
    sh_byte        = job.byte0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_STB0;
      end
      ST_STB0: begin
        strobe_nxt  = 1'b0;
        sh_ctl.load = fire;
        sh_byte     = job.byte0;
        state_nxt   = ST_BYTE0;
      end
      ST_BYTE0: begin
        clock_nxt   = sh_stat.phase;
        data_nxt    = sh_stat.bit_val;
        sh_ctl.step = fire;
        if (sh_stat.done) state_nxt = job.long_frame ? ST_STB1 : ST_STB3;
      end
      ST_STB1: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_STB2;
      end
      ST_STB2: begin
        strobe_nxt  = 1'b0;
        sh_ctl.load = fire;
        sh_byte     = job.byte1;
        state_nxt   = ST_BYTE1;
      end
      ST_BYTE1: begin
        clock_nxt   = sh_stat.phase;
        data_nxt    = sh_stat.bit_val;
        sh_ctl.step = fire;
        sh_byte     = job.byte2;
        if (sh_stat.done) begin
          sh_ctl.load = fire;
          state_nxt   = ST_BYTE2;
        end
      end
      ST_BYTE2: begin
        clock_nxt   = sh_stat.phase;
        data_nxt    = sh_stat.bit_val;
        sh_ctl.step = fire;
        if (sh_stat.done) state_nxt = ST_STB3;
      end
      ST_STB3: begin
        strobe_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (state_r != ST_IDLE) begin
      if (fire) begin
        out_tvalid_nxt = 1'b1;
        out_tdata_nxt  = {5'b0, data_nxt, clock_nxt, strobe_nxt};
        out_tlast_nxt  = (state_r == ST_STB3);
      end else begin
        // hold everything while the output slot is occupied
        state_nxt  = state_r;
        strobe_nxt = strobe_r;
        clock_nxt  = clock_r;
        data_nxt   = data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      strobe_r     <= 1'b1;
      clock_r      <= 1'b1;
      data_r       <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      strobe_r     <= strobe_nxt;
      clock_r      <= clock_nxt;
      data_r       <= data_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign idle       = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTHESIS
  a_idle_strobe_high: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> strobe_r)
    else $error("strobe low while idle");

  a_byte_strobe_low: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BYTE0 || state_r == ST_BYTE1 || state_r == ST_BYTE2) |-> !strobe_r)
    else $error("strobe high during byte transfer");

  a_stall_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |=> $stable(strobe_r) && $stable(clock_r) && $stable(data_r))
    else $error("pin levels moved while output stalled");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fire && state_r == ST_STB3 |=> state_r == ST_IDLE && out_tlast_r && strobe_r)
    else $error("final strobe did not close the command");
`endif

endmodule

`default_nettype wire

FILE: sv/led_display_serial_writer.sv
// Top level of the LED display serial writer: command capture and byte formation.
`timescale 1ns / 1ps
`default_nettype none

// Takes one display command per input transaction and emits the pin snapshots of a
// three-wire strobe/clock/data link, one snapshot per output transaction, LSB first,
// with out_tlast on the final snapshot of each command. A display-on command gives
// 18 snapshots and a digit or LED write gives 52; action code 3 is accepted and
// dropped with no output. The frame sequencer emits at most one snapshot per cycle,
// held while out_tready is low, through a bit-serial byte shifter, and a new command
// is taken once the sequencer has returned to idle after the last snapshot of the
// previous one has been loaded. Pins idle high after reset.
module led_display_serial_writer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // position[2:0], value[10:3], brightness[13:11]
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // strobe_res[0], clock_res[1], data_line[2]
  output logic             out_tlast
);
  import ldsw_pkg::*;

  logic [1:0] action;
  logic [2:0] position;
  logic [7:0] value;
  logic [2:0] brightness;
  logic       accept;
  logic       start_r;
  logic       seq_idle;
  job_t       job_r, job_nxt;
  logic [7:0] seg;

  assign action     = in_tuser;
  assign position   = in_tdata[2:0];
  assign value      = in_tdata[10:3];
  assign brightness = in_tdata[13:11];

  assign in_tready = seq_idle && !start_r;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    seg = value;
    if (position == DOT_POSITION && value != 8'd0) seg = value | DOT_BIT;
    job_nxt.long_frame = (action != ACT_DISPLAY_ON);
    job_nxt.byte0      = (action == ACT_DISPLAY_ON) ?
                         (CMD_DISPLAY_ON | {5'b0, brightness}) : CMD_DATA_FIXED;
    job_nxt.byte1      = {CMD_ADDR_HI, position, action == ACT_LED};
    job_nxt.byte2      = (action == ACT_LED) ? {7'b0, value != 8'd0} : seg;
  end

  always_ff @(posedge clk) begin
    if (accept) job_r <= job_nxt;
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      start_r <= accept && (action == ACT_DISPLAY_ON || action == ACT_DIGIT ||
                            action == ACT_LED);
    end
  end

  ldsw_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start_r),
    .job        (job_r),
    .idle       (seq_idle),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
